FILE: rtl/lens_distortion_point_map_unit_macros.svh
// Assertion macros for the lens distortion point map unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef LENS_DISTORTION_POINT_MAP_UNIT_MACROS_SVH
`define LENS_DISTORTION_POINT_MAP_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LDPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define LDPM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `LDPM_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/ldpm_pkg.sv
// Shared types, constants and rounding helper for the lens distortion point map.
// No dependencies.
package ldpm_pkg;

  localparam int FRAC      = 20;
  localparam int QBITS     = 23;
  localparam int DIV_LAT   = QBITS + 2;
  localparam int TOP_STG   = 12;
  localparam int COORD_MAX_DEF = 8191;

  localparam logic [22:0] NORM_LIM = 23'h7FFFFF;
  localparam logic signed [27:0] OUT_MAX = 28'sd8388607;
  localparam logic signed [27:0] OUT_MIN = -28'sd8388608;
  localparam logic signed [39:0] ONE_Q20 = 40'sd1048576;

  localparam logic [23:0] FOCAL_X_RST  = 24'd256000;
  localparam logic [23:0] FOCAL_Y_RST  = 24'd256000;
  localparam logic [21:0] CENTER_X_RST = 22'd245760;
  localparam logic [21:0] CENTER_Y_RST = 22'd138240;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_P1       = 3'd6,
    REG_P2       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [12:0] pixel_col;
    logic [12:0] pixel_row;
  } ldpm_point_t;

  typedef struct packed {
    logic signed [23:0] mapped_x;
    logic signed [23:0] mapped_y;
    logic               clipped;
  } ldpm_result_t;

  // shift right by FRAC, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_q20(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

FILE: rtl/ldpm_div.sv
// Pipelined restoring divider: signed Q.8 offset over Q.8 focal length to Q.20.
// Depends on ldpm_pkg; one quotient bit per stage, saturating on overflow.
module ldpm_div import ldpm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [23:0] diff_i,
  input  logic [23:0]        focal_i,
  output logic               valid_o,
  output logic signed [23:0] quot_o,
  output logic               clip_o
);

  logic [43:0] rem_q [0:QBITS-1];
  logic [22:0] quo_q [0:QBITS];
  logic        neg_q [0:QBITS];
  logic        ovf_q [0:QBITS];
  logic        vld_q [0:QBITS];

  logic        neg_d;
  logic [22:0] mag_d;
  logic [43:0] num_d;
  logic        ovf_d;

  logic               vld_out_q;
  logic signed [23:0] quot_q;
  logic               clip_q;
  logic [22:0]        qsat;

  always_comb begin
    neg_d = diff_i[23];
    mag_d = neg_d ? 23'(-diff_i) : diff_i[22:0];
    num_d = {1'b0, mag_d, 20'b0} + 44'(focal_i >> 1);
    ovf_d = {3'b0, num_d} >= {focal_i, 23'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_d;
    quo_q[0] <= '0;
    neg_q[0] <= neg_d;
    ovf_q[0] <= ovf_d;
  end

  for (genvar s = 1; s <= QBITS; s++) begin : g_stage
    localparam int B = QBITS - s;
    logic [46:0] sh;
    logic        ge;
    assign sh = 47'(focal_i) << B;
    assign ge = {3'b0, rem_q[s-1]} >= sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    if (s < QBITS) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge ? 44'({3'b0, rem_q[s-1]} - sh) : rem_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[s] <= quo_q[s-1] | (23'(ge) << B);
      neg_q[s] <= neg_q[s-1];
      ovf_q[s] <= ovf_q[s-1];
    end
  end

  assign qsat = ovf_q[QBITS] ? NORM_LIM : quo_q[QBITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= neg_q[QBITS] ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
    clip_q <= ovf_q[QBITS];
  end

  assign valid_o = vld_out_q;
  assign quot_o  = quot_q;
  assign clip_o  = clip_q;

endmodule

FILE: rtl/lens_distortion_point_map_unit.sv
// Lens distortion point map (radial k1 k2, tangential p1 p2), fixed point.
// One point per cycle, busy stays low.
// Depth: one offset stage, two parallel 25-stage dividers, then 12 arithmetic stages.
// Asynchronous active-low reset clears the pipeline valids and loads the register defaults.
// Depends on ldpm_pkg, ldpm_div and lens_distortion_point_map_unit_macros.svh.
`include "lens_distortion_point_map_unit_macros.svh"
module lens_distortion_point_map_unit import ldpm_pkg::*; #(
  parameter int COORD_MAX = COORD_MAX_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  ldpm_point_t  point_i,
  output logic         result_valid_o,
  output ldpm_result_t result_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int PIPE_LAT = 1 + DIV_LAT + TOP_STG;

  logic [23:0]        focal_x_q, focal_y_q;
  logic [21:0]        center_x_q, center_y_q;
  logic signed [23:0] k1_q, k2_q, p1_q, p2_q;
  reg_idx_e           idx;
  logic               wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_X_RST;
      focal_y_q  <= FOCAL_Y_RST;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      k1_q       <= '0;
      k2_q       <= '0;
      p1_q       <= '0;
      p2_q       <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_FOCAL_X:  focal_x_q  <= pwdata[23:0];
        REG_FOCAL_Y:  focal_y_q  <= pwdata[23:0];
        REG_CENTER_X: center_x_q <= pwdata[21:0];
        REG_CENTER_Y: center_y_q <= pwdata[21:0];
        REG_K1:       k1_q       <= pwdata[23:0];
        REG_K2:       k2_q       <= pwdata[23:0];
        REG_P1:       p1_q       <= pwdata[23:0];
        REG_P2:       p2_q       <= pwdata[23:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FOCAL_X:  prdata = 32'(focal_x_q);
      REG_FOCAL_Y:  prdata = 32'(focal_y_q);
      REG_CENTER_X: prdata = 32'(center_x_q);
      REG_CENTER_Y: prdata = 32'(center_y_q);
      REG_K1:       prdata = {8'b0, k1_q};
      REG_K2:       prdata = {8'b0, k2_q};
      REG_P1:       prdata = {8'b0, p1_q};
      REG_P2:       prdata = {8'b0, p2_q};
      default:      prdata = '0;
    endcase
  end

  logic [23:0] fex, fey;
  assign fex = (focal_x_q == '0) ? 24'd1 : focal_x_q;
  assign fey = (focal_y_q == '0) ? 24'd1 : focal_y_q;

  // clamp and offset by the principal point
  logic [12:0]        col_cl, row_cl;
  logic               s0_vld_q;
  logic signed [23:0] dx_q, dy_q;

  assign col_cl = (32'(point_i.pixel_col) > COORD_MAX) ? 13'(COORD_MAX) : point_i.pixel_col;
  assign row_cl = (32'(point_i.pixel_row) > COORD_MAX) ? 13'(COORD_MAX) : point_i.pixel_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= $signed({3'b0, col_cl, 8'b0}) - $signed({2'b0, center_x_q});
    dy_q <= $signed({3'b0, row_cl, 8'b0}) - $signed({2'b0, center_y_q});
  end

  logic               dvx, dvy, clx, cly;
  logic signed [23:0] nx, ny;

  ldpm_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_vld_q),
    .diff_i  (dx_q),
    .focal_i (fex),
    .valid_o (dvx),
    .quot_o  (nx),
    .clip_o  (clx)
  );

  ldpm_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_vld_q),
    .diff_i  (dy_q),
    .focal_i (fey),
    .valid_o (dvy),
    .quot_o  (ny),
    .clip_o  (cly)
  );

  logic [TOP_STG-1:0] vp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
    end else begin
      vp_q <= {vp_q[TOP_STG-2:0], dvx};
    end
  end

  // stage 1: squares and cross product
  logic signed [23:0] x1_q, y1_q;
  logic               c1_q;
  logic signed [47:0] pxx1_q, pyy1_q, pxy1_q;
  // stage 2
  logic signed [23:0] x2_q, y2_q;
  logic               c2_q;
  logic signed [27:0] xx2_q, yy2_q, xy2_q;
  logic signed [28:0] r22_q;
  // stage 3
  logic signed [23:0] x3_q, y3_q;
  logic               c3_q;
  logic signed [30:0] tx3_q, ty3_q;
  logic signed [57:0] r4p3_q;
  logic signed [52:0] k1p3_q;
  logic signed [51:0] q13_q, q23_q;
  // stage 4
  logic signed [23:0] x4_q, y4_q;
  logic               c4_q;
  logic signed [37:0] r44_q;
  logic signed [33:0] k1r24_q;
  logic signed [32:0] t1x4_q, t2y4_q;
  logic signed [54:0] p2tx4_q, p1ty4_q;
  // stage 5
  logic signed [23:0] x5_q, y5_q;
  logic               c5_q;
  logic signed [42:0] ph5_q;
  logic signed [43:0] pl5_q;
  logic signed [39:0] radp5_q, tanx5_q, tany5_q;
  // stage 6
  logic signed [23:0] x6_q, y6_q;
  logic               c6_q;
  logic signed [39:0] rad6_q, tanx6_q, tany6_q;
  // stage 7
  logic               c7_q;
  logic signed [43:0] pxh7_q, pyh7_q;
  logic signed [44:0] pxl7_q, pyl7_q;
  logic signed [39:0] tanx7_q, tany7_q;
  // stage 8
  logic               c8_q;
  logic signed [44:0] xd8_q, yd8_q;
  // stage 9
  logic               c9_q, nx9_q, ny9_q;
  logic [43:0]        mx9_q, my9_q;
  // stage 10
  logic               c10_q, nx10_q, ny10_q;
  logic [45:0]        mhx10_q, mlx10_q, mhy10_q, mly10_q;
  // stage 11
  logic               c11_q, nx11_q, ny11_q, ovx11_q, ovy11_q;
  logic [25:0]        rx11_q, ry11_q;
  // stage 12
  ldpm_result_t       result_q;

  logic [67:0]        totx, toty;
  logic signed [27:0] sx, sy;
  logic               satx, saty;
  logic signed [23:0] ox, oy;

  always_comb begin
    totx = {mhx10_q, 22'b0} + 68'(mlx10_q);
    toty = {mhy10_q, 22'b0} + 68'(mly10_q);
    sx   = (nx11_q ? -$signed({2'b0, rx11_q}) : $signed({2'b0, rx11_q}))
           + $signed({6'b0, center_x_q});
    sy   = (ny11_q ? -$signed({2'b0, ry11_q}) : $signed({2'b0, ry11_q}))
           + $signed({6'b0, center_y_q});
    satx = ovx11_q | (sx > OUT_MAX) | (sx < OUT_MIN);
    saty = ovy11_q | (sy > OUT_MAX) | (sy < OUT_MIN);
    if (ovx11_q) begin
      ox = nx11_q ? 24'(OUT_MIN) : 24'(OUT_MAX);
    end else if (sx > OUT_MAX) begin
      ox = 24'(OUT_MAX);
    end else if (sx < OUT_MIN) begin
      ox = 24'(OUT_MIN);
    end else begin
      ox = 24'(sx);
    end
    if (ovy11_q) begin
      oy = ny11_q ? 24'(OUT_MIN) : 24'(OUT_MAX);
    end else if (sy > OUT_MAX) begin
      oy = 24'(OUT_MAX);
    end else if (sy < OUT_MIN) begin
      oy = 24'(OUT_MIN);
    end else begin
      oy = 24'(sy);
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= nx;
    y1_q    <= ny;
    c1_q    <= clx | cly;
    pxx1_q  <= 48'(nx) * 48'(nx);
    pyy1_q  <= 48'(ny) * 48'(ny);
    pxy1_q  <= 48'(nx) * 48'(ny);

    x2_q    <= x1_q;
    y2_q    <= y1_q;
    c2_q    <= c1_q;
    xx2_q   <= 28'(rnd_q20(64'(pxx1_q)));
    yy2_q   <= 28'(rnd_q20(64'(pyy1_q)));
    xy2_q   <= 28'(rnd_q20(64'(pxy1_q)));
    r22_q   <= 29'(rnd_q20(64'(pxx1_q))) + 29'(rnd_q20(64'(pyy1_q)));

    x3_q    <= x2_q;
    y3_q    <= y2_q;
    c3_q    <= c2_q;
    tx3_q   <= 31'(r22_q) + (31'(xx2_q) <<< 1);
    ty3_q   <= 31'(r22_q) + (31'(yy2_q) <<< 1);
    r4p3_q  <= 58'(r22_q) * 58'(r22_q);
    k1p3_q  <= 53'(k1_q) * 53'(r22_q);
    q13_q   <= 52'(p1_q) * 52'(xy2_q);
    q23_q   <= 52'(p2_q) * 52'(xy2_q);

    x4_q    <= x3_q;
    y4_q    <= y3_q;
    c4_q    <= c3_q;
    r44_q   <= 38'(rnd_q20(64'(r4p3_q)));
    k1r24_q <= 34'(rnd_q20(64'(k1p3_q)));
    t1x4_q  <= 33'(rnd_q20(64'(q13_q) <<< 1));
    t2y4_q  <= 33'(rnd_q20(64'(q23_q) <<< 1));
    p2tx4_q <= 55'(p2_q) * 55'(tx3_q);
    p1ty4_q <= 55'(p1_q) * 55'(ty3_q);

    x5_q    <= x4_q;
    y5_q    <= y4_q;
    c5_q    <= c4_q;
    ph5_q   <= 43'(k2_q) * 43'(r44_q >>> 19);
    pl5_q   <= 44'(k2_q) * $signed({25'b0, r44_q[18:0]});
    radp5_q <= ONE_Q20 + 40'(k1r24_q);
    tanx5_q <= 40'(t1x4_q) + 40'(rnd_q20(64'(p2tx4_q)));
    tany5_q <= 40'(rnd_q20(64'(p1ty4_q))) + 40'(t2y4_q);

    x6_q    <= x5_q;
    y6_q    <= y5_q;
    c6_q    <= c5_q;
    rad6_q  <= radp5_q + 40'(rnd_q20((64'(ph5_q) <<< 19) + 64'(pl5_q)));
    tanx6_q <= tanx5_q;
    tany6_q <= tany5_q;

    c7_q    <= c6_q;
    pxh7_q  <= 44'(x6_q) * 44'(rad6_q >>> 20);
    pyh7_q  <= 44'(y6_q) * 44'(rad6_q >>> 20);
    pxl7_q  <= 45'(x6_q) * $signed({25'b0, rad6_q[19:0]});
    pyl7_q  <= 45'(y6_q) * $signed({25'b0, rad6_q[19:0]});
    tanx7_q <= tanx6_q;
    tany7_q <= tany6_q;

    c8_q    <= c7_q;
    xd8_q   <= 45'(rnd_q20((64'(pxh7_q) <<< 20) + 64'(pxl7_q))) + 45'(tanx7_q);
    yd8_q   <= 45'(rnd_q20((64'(pyh7_q) <<< 20) + 64'(pyl7_q))) + 45'(tany7_q);

    c9_q    <= c8_q;
    nx9_q   <= xd8_q[44];
    ny9_q   <= yd8_q[44];
    mx9_q   <= xd8_q[44] ? 44'(-xd8_q) : xd8_q[43:0];
    my9_q   <= yd8_q[44] ? 44'(-yd8_q) : yd8_q[43:0];

    c10_q   <= c9_q;
    nx10_q  <= nx9_q;
    ny10_q  <= ny9_q;
    mhx10_q <= 46'(mx9_q[43:22]) * 46'(fex);
    mlx10_q <= 46'(mx9_q[21:0]) * 46'(fex);
    mhy10_q <= 46'(my9_q[43:22]) * 46'(fey);
    mly10_q <= 46'(my9_q[21:0]) * 46'(fey);

    c11_q   <= c10_q;
    nx11_q  <= nx10_q;
    ny11_q  <= ny10_q;
    ovx11_q <= totx > (68'd1 << 45);
    ovy11_q <= toty > (68'd1 << 45);
    rx11_q  <= 26'((totx + (68'd1 << (FRAC - 1))) >> FRAC);
    ry11_q  <= 26'((toty + (68'd1 << (FRAC - 1))) >> FRAC);

    result_q.mapped_x <= ox;
    result_q.mapped_y <= oy;
    result_q.clipped  <= c11_q | satx | saty;
  end

  assign result_valid_o = vp_q[TOP_STG-1];
  assign result_o       = result_q;

  `LDPM_ASSERT(a_div_lockstep, clk_i, rst_ni, dvx == dvy, "divider lanes out of step")
  `LDPM_ASSERT(a_latency, clk_i, rst_ni, (start && !busy) |-> ##PIPE_LAT result_valid_o, "beat lost")
  `LDPM_ASSERT(a_no_phantom, clk_i, rst_ni, result_valid_o |-> $past(start, PIPE_LAT), "phantom beat")
  `LDPM_ASSERT_NEVER(a_no_stall, clk_i, rst_ni, busy && s0_vld_q, "busy while in flight")

endmodule

FILE: tb/tb_lens_distortion_point_map_unit.sv
// Testbench for lens_distortion_point_map_unit: drives pixel points and APB register
// writes, predicts each mapped point in fixed point and checks every result beat.
// Depends on ldpm_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_lens_distortion_point_map_unit;
  import ldpm_pkg::*;

  localparam int COORD_LIMIT = 8191;
  localparam int LATENCY     = 38;
  localparam int WDOG_LIMIT  = 2000;
  localparam int N_RANDOM    = 550;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  ldpm_point_t  point_i = '0;
  logic         result_valid_o;
  ldpm_result_t result_o;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  lens_distortion_point_map_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .point_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // lens settings as the predictor sees them
  logic [23:0] lens_fx, lens_fy;
  logic [21:0] lens_cx, lens_cy;
  logic [23:0] lens_k1, lens_k2, lens_p1, lens_p2;

  ldpm_point_t  point_queue[$];
  ldpm_result_t mapped_queue[$];
  int errors = 0;
  int wdog = 0;

  function automatic longint round_q20(longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< 19)) >>> 20;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint norm_coord(longint d, longint f, ref bit clip);
    longint m, q;
    m = d < 0 ? -d : d;
    q = ((m <<< 20) + f / 2) / f;
    if (q > 64'sd8388607) begin
      q = 64'sd8388607;
      clip = 1'b1;
    end
    return d < 0 ? -q : q;
  endfunction

  function automatic longint to_pixels(longint v, longint f, longint c, ref bit clip);
    longint m, r;
    m = v < 0 ? -v : v;
    if (m > (64'sd1 <<< 45) / f) begin
      clip = 1'b1;
      return v < 0 ? -64'sd8388608 : 64'sd8388607;
    end
    r = round_q20(v * f) + c;
    if (r > 64'sd8388607) begin
      clip = 1'b1;
      return 64'sd8388607;
    end
    if (r < -64'sd8388608) begin
      clip = 1'b1;
      return -64'sd8388608;
    end
    return r;
  endfunction

  function automatic ldpm_result_t map_point(ldpm_point_t p);
    ldpm_result_t res;
    bit clip;
    longint fx, fy, cx, cy, k1, k2, p1, p2, u, v;
    longint x, y, xx, yy, xy, r2, r4, rad, xd, yd, mx, my;
    clip = 1'b0;
    fx = lens_fx == 0 ? 1 : longint'(lens_fx);
    fy = lens_fy == 0 ? 1 : longint'(lens_fy);
    cx = longint'(lens_cx);
    cy = longint'(lens_cy);
    k1 = longint'($signed(lens_k1));
    k2 = longint'($signed(lens_k2));
    p1 = longint'($signed(lens_p1));
    p2 = longint'($signed(lens_p2));
    u = p.pixel_col > COORD_LIMIT ? COORD_LIMIT : longint'(p.pixel_col);
    v = p.pixel_row > COORD_LIMIT ? COORD_LIMIT : longint'(p.pixel_row);
    x = norm_coord(u * 256 - cx, fx, clip);
    y = norm_coord(v * 256 - cy, fy, clip);
    xx = round_q20(x * x);
    yy = round_q20(y * y);
    xy = round_q20(x * y);
    r2 = xx + yy;
    r4 = round_q20(r2 * r2);
    rad = (64'sd1 <<< 20) + round_q20(k1 * r2) + round_q20(k2 * r4);
    xd = round_q20(x * rad) + round_q20(2 * p1 * xy) + round_q20(p2 * (r2 + 2 * xx));
    yd = round_q20(y * rad) + round_q20(p1 * (r2 + 2 * yy)) + round_q20(2 * p2 * xy);
    mx = to_pixels(xd, fx, cx, clip);
    my = to_pixels(yd, fy, cy, clip);
    res.mapped_x = mx[23:0];
    res.mapped_y = my[23:0];
    res.clipped = clip;
    return res;
  endfunction

  // driver: issue pending points with random gaps
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (start && !busy) begin
      mapped_queue.insert(mapped_queue.size(), map_point(point_i));
    end
    if (start && busy) begin
      // hold the current beat
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (point_queue.size() > 0) begin
      point_i <= point_queue.pop_front();
      start <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    ldpm_result_t exp_res;
    if (rst_ni && result_valid_o) begin
      if (mapped_queue.size() == 0) begin
        $error("result beat with no point pending");
        errors++;
      end else begin
        exp_res = mapped_queue.pop_front();
        if (result_o.mapped_x !== exp_res.mapped_x) begin
          $error("mapped_x expected %0d got %0d", exp_res.mapped_x, result_o.mapped_x);
          errors++;
        end
        if (result_o.mapped_y !== exp_res.mapped_y) begin
          $error("mapped_y expected %0d got %0d", exp_res.mapped_y, result_o.mapped_y);
          errors++;
        end
        if (result_o.clipped !== exp_res.clipped) begin
          $error("clipped expected %0b got %0b", exp_res.clipped, result_o.clipped);
          errors++;
        end
      end
    end
    if ((rst_ni && result_valid_o) || (start && !busy)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
    end
    if (wdog >= WDOG_LIMIT) begin
      $display("tb_lens_distortion_point_map_unit: done, errors");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    unique case (idx)
      REG_FOCAL_X:  lens_fx = val[23:0];
      REG_FOCAL_Y:  lens_fy = val[23:0];
      REG_CENTER_X: lens_cx = val[21:0];
      REG_CENTER_Y: lens_cy = val[21:0];
      REG_K1:       lens_k1 = val[23:0];
      REG_K2:       lens_k2 = val[23:0];
      REG_P1:       lens_p1 = val[23:0];
      REG_P2:       lens_p2 = val[23:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (point_queue.size() > 0 || start || mapped_queue.size() > 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_point(int col, int row);
    ldpm_point_t p;
    p.pixel_col = 13'(col);
    p.pixel_row = 13'(row);
    point_queue.insert(point_queue.size(), p);
  endtask

  task automatic random_lens();
    reg_write(REG_FOCAL_X, $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(64000, 600000));
    reg_write(REG_FOCAL_Y, $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(64000, 600000));
    reg_write(REG_CENTER_X, $urandom());
    reg_write(REG_CENTER_Y, $urandom());
    reg_write(REG_K1, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 400000) - 200000);
    reg_write(REG_K2, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 200000) - 100000);
    reg_write(REG_P1, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20000) - 10000);
    reg_write(REG_P2, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20000) - 10000);
  endtask

  initial begin
    lens_fx = FOCAL_X_RST;
    lens_fy = FOCAL_Y_RST;
    lens_cx = CENTER_X_RST;
    lens_cy = CENTER_Y_RST;
    lens_k1 = '0;
    lens_k2 = '0;
    lens_p1 = '0;
    lens_p2 = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default lens: corners, center and one interior point
    add_point(0, 0);
    add_point(8191, 8191);
    add_point(960, 540);
    add_point(8191, 0);
    add_point(0, 8191);
    add_point(5461, 2730);
    drain();

    // strong distortion with extreme coefficients
    reg_write(REG_K1, 32'h7FFFFF);
    reg_write(REG_K2, 32'h800000);
    reg_write(REG_P1, 32'h7FFFFF);
    reg_write(REG_P2, 32'h800000);
    add_point(0, 0);
    add_point(8191, 8191);
    add_point(961, 541);
    add_point(1200, 300);
    drain();

    // zero and tiny focal length, extreme centers
    reg_write(REG_FOCAL_X, 32'd0);
    reg_write(REG_FOCAL_Y, 32'd1);
    reg_write(REG_CENTER_X, 32'h3FFFFF);
    reg_write(REG_CENTER_Y, 32'd0);
    add_point(0, 0);
    add_point(8191, 8191);
    add_point(4096, 2048);
    drain();

    reg_write(REG_FOCAL_X, 32'hFFFFFF);
    reg_write(REG_FOCAL_Y, 32'hFFFFFF);
    reg_write(REG_K1, 32'd0);
    reg_write(REG_K2, 32'd0);
    reg_write(REG_P1, 32'd0);
    reg_write(REG_P2, 32'd0);
    add_point(0, 8191);
    add_point(8191, 0);
    add_point(16383 & 8191, 4095);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      random_lens();
      for (int i = 0; i < N_RANDOM / 5; i++)
        add_point($urandom_range(0, 8191), $urandom_range(0, 8191));
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && mapped_queue.size() == 0)
      $display("tb_lens_distortion_point_map_unit: done, clean");
    else
      $display("tb_lens_distortion_point_map_unit: done, errors");
    $finish;
  end
endmodule
